// File: src/isps_pkg.sv
// ----------------------------------------------------------------------------
// isps_pkg: shared types and constants
// Field widths, register codes, reset values and queue status for the
// interleaved sample period statistics block.
// ----------------------------------------------------------------------------
package isps_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int AVG_W     = 25;
    localparam int SWING_W   = 24;
    localparam int INDEX_W   = 2;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_MAX_LAG     = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_W-1:0] PEDESTAL_RST  = 24'd3145728;
    localparam logic [CFG_W-1:0] SAT_LEVEL_RST = 24'd3200000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEDESTAL  = 1'b0,
        REG_SAT_LEVEL = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_LAG     = 1'b0,
        KIND_CHANNEL = 1'b1
    } kind_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

endpackage

// File: src/isps_if.sv
// ----------------------------------------------------------------------------
// isps_if: sample and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface isps_in_if;

    logic                             valid;
    logic                             ready;
    logic [isps_pkg::SAMPLE_W-1:0]    sample;
    logic                             end_of_run;

    modport source (output valid, output sample, output end_of_run, input ready);
    modport sink   (input valid, input sample, input end_of_run, output ready);

endinterface

interface isps_out_if;

    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [isps_pkg::INDEX_W-1:0]     index;
    logic signed [isps_pkg::AVG_W-1:0] average;
    logic [isps_pkg::SWING_W-1:0]     swing;
    logic                             valid_res;
    logic                             saturated;
    logic                             final_result;

    modport source (output valid, output kind, output index, output average,
                    output swing, output valid_res, output saturated,
                    output final_result, input ready);
    modport sink   (input valid, input kind, input index, input average,
                    input swing, input valid_res, input saturated,
                    input final_result, output ready);

endinterface

// File: src/isps_front.sv
// ----------------------------------------------------------------------------
// isps_front: sample accumulator
// Takes one sample per cycle while the queue has room, updates lag and channel
// accumulators and pushes a finished run record into the queue at run end.
// ----------------------------------------------------------------------------
module isps_front #(
    parameter int MAX_SAMPLES = isps_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_LAG     = isps_pkg::DEF_MAX_LAG,
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1),
    localparam int SUM_W      = isps_pkg::SAMPLE_W + $clog2(MAX_SAMPLES)
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    isps_in_if.sink                                  samples,
    input  isps_pkg::q_status_t                      q_status,
    output logic                                     push,
    output logic [CNT_W-1:0]                         rec_count,
    output logic [MAX_LAG-1:0][SUM_W-1:0]            rec_lag_sums,
    output logic [1:0][SUM_W-1:0]                    rec_ch_sums,
    output logic [1:0][isps_pkg::SAMPLE_W-1:0]       rec_ch_mins,
    output logic [1:0][isps_pkg::SAMPLE_W-1:0]       rec_ch_maxs
);

    localparam int SW = isps_pkg::SAMPLE_W;

    logic [SW-1:0]                  hist_reg [MAX_LAG];
    logic [SW-1:0]                  hist_next [MAX_LAG];
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [MAX_LAG-1:0][SUM_W-1:0]  lag_sum_reg, lag_sum_next;
    logic [1:0][SUM_W-1:0]          ch_sum_reg, ch_sum_next;
    logic [1:0][SW-1:0]             ch_min_reg, ch_min_next;
    logic [1:0][SW-1:0]             ch_max_reg, ch_max_next;

    logic          take;
    logic          counted;
    logic          ch;
    logic [SW-1:0] x;
    logic [SW-1:0] diff;

    assign samples.ready = !q_status.full;
    assign take          = samples.valid && samples.ready;
    assign push          = take && samples.end_of_run;

    always_comb
    begin
        x            = samples.sample;
        ch           = count_reg[0];
        counted      = count_reg < CNT_W'(MAX_SAMPLES);
        diff         = '0;
        hist_next    = hist_reg;
        count_next   = count_reg;
        lag_sum_next = lag_sum_reg;
        ch_sum_next  = ch_sum_reg;
        ch_min_next  = ch_min_reg;
        ch_max_next  = ch_max_reg;
        if (counted)
        begin
            for (int k = 0; k < MAX_LAG; k++)
            begin
                if (count_reg > CNT_W'(k))
                begin
                    diff = (x >= hist_reg[k]) ? x - hist_reg[k] : hist_reg[k] - x;
                    lag_sum_next[k] = lag_sum_reg[k] + SUM_W'(diff);
                end
            end
            hist_next[0] = x;
            for (int k = 1; k < MAX_LAG; k++)
            begin
                hist_next[k] = hist_reg[k-1];
            end
            ch_sum_next[ch] = ch_sum_reg[ch] + SUM_W'(x);
            if (x < ch_min_reg[ch])
            begin
                ch_min_next[ch] = x;
            end
            if (x > ch_max_reg[ch])
            begin
                ch_max_next[ch] = x;
            end
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign rec_count    = count_next;
    assign rec_lag_sums = lag_sum_next;
    assign rec_ch_sums  = ch_sum_next;
    assign rec_ch_mins  = ch_min_next;
    assign rec_ch_maxs  = ch_max_next;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            lag_sum_reg <= '0;
            ch_sum_reg  <= '0;
            ch_min_reg  <= '1;
            ch_max_reg  <= '0;
        end
        else if (take)
        begin
            if (samples.end_of_run)
            begin
                // clear for the next run
                count_reg   <= '0;
                lag_sum_reg <= '0;
                ch_sum_reg  <= '0;
                ch_min_reg  <= '1;
                ch_max_reg  <= '0;
            end
            else
            begin
                count_reg   <= count_next;
                lag_sum_reg <= lag_sum_next;
                ch_sum_reg  <= ch_sum_next;
                ch_min_reg  <= ch_min_next;
                ch_max_reg  <= ch_max_next;
            end
        end
    end

endmodule

// File: src/isps_queue.sv
// ----------------------------------------------------------------------------
// isps_queue: run record queue
// Short register FIFO that holds finished run records for the back end.
// ----------------------------------------------------------------------------
module isps_queue #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = isps_pkg::QUEUE_DEPTH,
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wdata,
    input  logic                pop,
    output logic [WIDTH-1:0]    rdata,
    output isps_pkg::q_status_t status
);

    logic [WIDTH-1:0]  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign status.full  = fill_reg == FILL_W'(DEPTH);
    assign status.avail = fill_reg != '0;
    assign rdata        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: src/isps_back.sv
// ----------------------------------------------------------------------------
// isps_back: result sequencer
// Walks the lag and channel results of one run record, divides each sum by
// its term count one quotient bit per cycle and hands the result out.
// ----------------------------------------------------------------------------
module isps_back #(
    parameter int MAX_SAMPLES = isps_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_LAG     = isps_pkg::DEF_MAX_LAG,
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1),
    localparam int SUM_W      = isps_pkg::SAMPLE_W + $clog2(MAX_SAMPLES)
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [isps_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [isps_pkg::CFG_W-1:0]               cfg_data,
    input  isps_pkg::q_status_t                      q_status,
    output logic                                     pop,
    input  logic [CNT_W-1:0]                         rec_count,
    input  logic [MAX_LAG-1:0][SUM_W-1:0]            rec_lag_sums,
    input  logic [1:0][SUM_W-1:0]                    rec_ch_sums,
    input  logic [1:0][isps_pkg::SAMPLE_W-1:0]       rec_ch_mins,
    input  logic [1:0][isps_pkg::SAMPLE_W-1:0]       rec_ch_maxs,
    isps_out_if.source                               results
);

    localparam int SW        = isps_pkg::SAMPLE_W;
    localparam int AW        = isps_pkg::AVG_W;
    localparam int RES_W     = $clog2(MAX_LAG + 2);
    localparam int LAG_IDX_W = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int STEP_W    = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [RES_W-1:0]              res_reg, res_next;
    logic [SUM_W-1:0]              quo_reg, quo_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]              div_reg, div_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          empty_reg, empty_next;
    logic [isps_pkg::CFG_W-1:0]    pedestal_reg;
    logic [isps_pkg::CFG_W-1:0]    sat_level_reg;

    logic                          out_valid_reg, out_valid_next;
    logic                          kind_reg, kind_next;
    logic [isps_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic signed [AW-1:0]          average_reg, average_next;
    logic [isps_pkg::SWING_W-1:0]  swing_reg, swing_next;
    logic                          valid_res_reg, valid_res_next;
    logic                          saturated_reg, saturated_next;
    logic                          final_reg, final_next;

    logic                 is_lag;
    logic                 last_res;
    logic                 ch;
    logic                 emit_ok;
    logic                 ge;
    logic [LAG_IDX_W-1:0] lag_idx;
    logic [CNT_W-1:0]     lag_len;
    logic [CNT_W-1:0]     divisor;
    logic [SUM_W-1:0]     dividend;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       trial_sub;
    logic [SW-1:0]        q24;

    always_comb
    begin
        is_lag    = res_reg < RES_W'(MAX_LAG);
        last_res  = res_reg == RES_W'(MAX_LAG + 1);
        ch        = res_reg != RES_W'(MAX_LAG);
        lag_idx   = res_reg[LAG_IDX_W-1:0];
        lag_len   = CNT_W'(res_reg) + CNT_W'(1);
        emit_ok   = !out_valid_reg || results.ready;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        ge        = trial >= {1'b0, div_reg};
        trial_sub = trial - {1'b0, div_reg};
        q24       = quo_reg[SW-1:0];
        if (is_lag)
        begin
            dividend = rec_lag_sums[lag_idx];
            divisor  = (rec_count > lag_len) ? rec_count - lag_len : '0;
        end
        else
        begin
            dividend = rec_ch_sums[ch];
            divisor  = ch ? (rec_count >> 1)
                          : (rec_count >> 1) + CNT_W'(rec_count[0]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        empty_next     = empty_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !results.ready;
        kind_next      = kind_reg;
        index_next     = index_reg;
        average_next   = average_reg;
        swing_next     = swing_reg;
        valid_res_next = valid_res_reg;
        saturated_next = saturated_reg;
        final_next     = final_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_status.avail)
                begin
                    res_next   = '0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                div_next   = divisor;
                quo_next   = dividend;
                rem_next   = '0;
                step_next  = STEP_W'(SUM_W);
                empty_next = divisor == '0;
                state_next = (divisor == '0) ? S_EMIT : S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    valid_res_next = !empty_reg;
                    final_next     = last_res;
                    if (is_lag)
                    begin
                        kind_next      = isps_pkg::KIND_LAG;
                        index_next     = res_reg[isps_pkg::INDEX_W-1:0];
                        average_next   = empty_reg ? '0 : AW'(q24);
                        swing_next     = '0;
                        saturated_next = 1'b0;
                    end
                    else
                    begin
                        kind_next    = isps_pkg::KIND_CHANNEL;
                        index_next   = isps_pkg::INDEX_W'(ch);
                        average_next = empty_reg ? '0
                                     : $signed({1'b0, q24}) - $signed({1'b0, pedestal_reg});
                        swing_next   = empty_reg ? '0 : rec_ch_maxs[ch] - rec_ch_mins[ch];
                        saturated_next = !empty_reg &&
                            ((q24 > sat_level_reg) ||
                             ((q24 == sat_level_reg) && (rem_reg != '0)));
                    end
                    if (last_res)
                    begin
                        pop        = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_next   = res_reg + RES_W'(1);
                        state_next = S_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pedestal_reg  <= isps_pkg::PEDESTAL_RST;
            sat_level_reg <= isps_pkg::SAT_LEVEL_RST;
        end
        else if (cfg_write)
        begin
            case (isps_pkg::cfg_reg_t'(cfg_index))
                isps_pkg::REG_PEDESTAL:  pedestal_reg  <= cfg_data;
                isps_pkg::REG_SAT_LEVEL: sat_level_reg <= cfg_data;
                default:                 pedestal_reg  <= pedestal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            step_reg      <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            index_reg     <= '0;
            average_reg   <= '0;
            swing_reg     <= '0;
            valid_res_reg <= 1'b0;
            saturated_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            div_reg       <= div_next;
            step_reg      <= step_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            index_reg     <= index_next;
            average_reg   <= average_next;
            swing_reg     <= swing_next;
            valid_res_reg <= valid_res_next;
            saturated_reg <= saturated_next;
            final_reg     <= final_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.kind         = kind_reg;
    assign results.index        = index_reg;
    assign results.average      = average_reg;
    assign results.swing        = swing_reg;
    assign results.valid_res    = valid_res_reg;
    assign results.saturated    = saturated_reg;
    assign results.final_result = final_reg;

endmodule

// File: src/interleaved_sample_period_stats.sv
// ----------------------------------------------------------------------------
// interleaved_sample_period_stats: lag difference and channel statistics
// Samples arrive on the samples channel, one transfer per cycle while the
// queue has room, the last sample of a run flagged by end_of_run. For lags
// 1 to MAX_LAG the block sums absolute differences; for the even and odd
// channels it keeps sum, minimum and maximum. Samples past MAX_SAMPLES in a
// run are dropped. On the last sample the run record moves into a two-entry
// queue and the accumulators clear, so the next run can start as soon as the
// queue has room. The back end then emits MAX_LAG lag results and two
// channel results on the results channel, final_result set on the last one.
// Each result is set up, divided by the bit-serial divider over SUM_W
// quotient bits (SUM_W = 24 + clog2(MAX_SAMPLES)) and emitted; a result with
// no terms skips the division. samples.ready drops only while two finished
// runs wait in the queue. A stalled receiver holds the output register;
// division of the next result continues behind it. Reset clears the
// accumulators, the queue and the output, and loads the register reset
// values. Write pedestal and saturation_level through cfg_write/cfg_index/
// cfg_data while idle.
// ----------------------------------------------------------------------------
module interleaved_sample_period_stats #(
    parameter int MAX_SAMPLES = isps_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_LAG     = isps_pkg::DEF_MAX_LAG
) (
    input  logic                              clk,
    input  logic                              rst_n,
    isps_in_if.sink                           samples,
    isps_out_if.source                        results,
    input  logic                              cfg_write,
    input  logic [isps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [isps_pkg::CFG_W-1:0]        cfg_data
);

    localparam int SW    = isps_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SW + $clog2(MAX_SAMPLES);
    localparam int REC_W = CNT_W + (MAX_LAG + 2) * SUM_W + 4 * SW;

    isps_pkg::q_status_t q_status;
    logic                push;
    logic                pop;
    logic [REC_W-1:0]    q_wdata;
    logic [REC_W-1:0]    q_rdata;

    logic [CNT_W-1:0]              f_count,    b_count;
    logic [MAX_LAG-1:0][SUM_W-1:0] f_lag_sums, b_lag_sums;
    logic [1:0][SUM_W-1:0]         f_ch_sums,  b_ch_sums;
    logic [1:0][SW-1:0]            f_ch_mins,  b_ch_mins;
    logic [1:0][SW-1:0]            f_ch_maxs,  b_ch_maxs;

    isps_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_LAG     (MAX_LAG)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples),
        .q_status     (q_status),
        .push         (push),
        .rec_count    (f_count),
        .rec_lag_sums (f_lag_sums),
        .rec_ch_sums  (f_ch_sums),
        .rec_ch_mins  (f_ch_mins),
        .rec_ch_maxs  (f_ch_maxs)
    );

    assign q_wdata = {f_count, f_lag_sums, f_ch_sums, f_ch_mins, f_ch_maxs};

    isps_queue #(
        .WIDTH (REC_W),
        .DEPTH (isps_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (q_wdata),
        .pop    (pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    assign {b_count, b_lag_sums, b_ch_sums, b_ch_mins, b_ch_maxs} = q_rdata;

    isps_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_LAG     (MAX_LAG)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_status     (q_status),
        .pop          (pop),
        .rec_count    (b_count),
        .rec_lag_sums (b_lag_sums),
        .rec_ch_sums  (b_ch_sums),
        .rec_ch_mins  (b_ch_mins),
        .rec_ch_maxs  (b_ch_maxs),
        .results      (results)
    );

endmodule

// File: verif/tb_interleaved_sample_period_stats.sv
// ----------------------------------------------------------------------------
// tb_interleaved_sample_period_stats: self-checking testbench
// Drives runs of samples over the sample channel and checks every result
// transfer, field by field, against a local model of the lag sums and the
// channel statistics, or for some directed runs a typed table. A short directed
// table opens the run, then random phases follow under several register settings,
// with random gaps and stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_interleaved_sample_period_stats;

    localparam int MAX_SAMPLES   = isps_pkg::DEF_MAX_SAMPLES;
    localparam int MAX_LAG       = isps_pkg::DEF_MAX_LAG;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 1500;
    localparam int PHASE_ITEMS   = 58;

    typedef struct packed {
        isps_pkg::kind_t                   kind;
        logic [isps_pkg::INDEX_W-1:0]      index;
        logic signed [isps_pkg::AVG_W-1:0] average;
        logic [isps_pkg::SWING_W-1:0]      swing;
        logic                              valid_res;
        logic                              saturated;
        logic                              final_result;
    } stat_rec_t;

    typedef enum {
        ROW_SAMPLE,
        ROW_CONFIG
    } row_op_t;

    typedef struct {
        row_op_t                       op;
        isps_pkg::cfg_reg_t            target;
        logic [isps_pkg::SAMPLE_W-1:0] value;
        logic                          eor;
        int                            typed_at;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                           cfg_write;
    logic [isps_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [isps_pkg::CFG_W-1:0]     cfg_data;

    isps_in_if  samples_ch ();
    isps_out_if results_ch ();

    interleaved_sample_period_stats dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .results   (results_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state
    logic [isps_pkg::CFG_W-1:0]    pedestal_reg  = isps_pkg::PEDESTAL_RST;
    logic [isps_pkg::CFG_W-1:0]    sat_level_reg = isps_pkg::SAT_LEVEL_RST;
    logic [isps_pkg::SAMPLE_W-1:0] history [MAX_LAG];
    int unsigned                   n_counted;
    logic [35:0]                   lag_acc [MAX_LAG];
    logic [35:0]                   ch_acc [2];
    logic [isps_pkg::SAMPLE_W-1:0] ch_lo [2];
    logic [isps_pkg::SAMPLE_W-1:0] ch_hi [2];

    stat_rec_t pending_stats [$];
    stat_rec_t typed_table [24];
    int        typed_pick = -1;

    int  faults          = 0;
    int  results_checked = 0;
    int  samples_taken   = 0;
    int  runs_seen       = 0;
    int  items_sent      = 0;
    bit  calm            = 0;
    bit  hold_results    = 0;
    bit  holding         = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("tb_interleaved_sample_period_stats failed");
        $finish;
    end

    function automatic void clear_run_state();
        int k;
        for (k = 0; k < MAX_LAG; k++)
        begin
            history[k] = '0;
            lag_acc[k] = '0;
        end
        n_counted = 0;
        for (k = 0; k < 2; k++)
        begin
            ch_acc[k] = '0;
            ch_lo[k]  = '1;
            ch_hi[k]  = '0;
        end
    endfunction

    function automatic stat_rec_t stat_rec(isps_pkg::kind_t kd, int idx, longint avg,
                                           int unsigned sw, bit v, bit s, bit f);
        stat_rec_t r;
        r.kind         = kd;
        r.index        = idx[isps_pkg::INDEX_W-1:0];
        r.average      = avg[isps_pkg::AVG_W-1:0];
        r.swing        = sw[isps_pkg::SWING_W-1:0];
        r.valid_res    = v;
        r.saturated    = s;
        r.final_result = f;
        return r;
    endfunction

    // accumulate one sample; on the end of a run queue its six results
    function automatic void track_sample(logic [isps_pkg::SAMPLE_W-1:0] x, logic eor);
        int          k;
        int unsigned ch;
        int unsigned cnt;
        longint      mean;
        stat_rec_t   r;
        if (n_counted < MAX_SAMPLES)
        begin
            for (k = 0; k < MAX_LAG; k++)
                if (n_counted > k)
                    lag_acc[k] += (x >= history[k]) ? x - history[k] : history[k] - x;
            for (k = MAX_LAG - 1; k > 0; k--)
                history[k] = history[k-1];
            history[0] = x;
            ch = n_counted & 1;
            ch_acc[ch] += x;
            if (x < ch_lo[ch])
                ch_lo[ch] = x;
            if (x > ch_hi[ch])
                ch_hi[ch] = x;
            n_counted++;
        end
        if (!eor)
            return;
        runs_seen++;
        if (typed_pick >= 0)
        begin
            for (k = 0; k < 6; k++)
                pending_stats.push_back(typed_table[typed_pick + k]);
            typed_pick = -1;
        end
        else
        begin
            for (k = 0; k < MAX_LAG; k++)
            begin
                cnt = (n_counted > k + 1) ? n_counted - k - 1 : 0;
                mean = (cnt != 0) ? longint'(lag_acc[k]) / cnt : 0;
                pending_stats.push_back(stat_rec(isps_pkg::KIND_LAG, k, mean, 0,
                                                 cnt != 0, 0, 0));
            end
            for (k = 0; k < 2; k++)
            begin
                cnt = (n_counted >> 1) + ((k == 0) ? (n_counted & 1) : 0);
                r = stat_rec(isps_pkg::KIND_CHANNEL, k, 0, 0, 0, 0, k == 1);
                if (cnt != 0)
                begin
                    mean = longint'(ch_acc[k]) / cnt;
                    r.average   = isps_pkg::AVG_W'(mean - longint'(pedestal_reg));
                    r.swing     = ch_hi[k] - ch_lo[k];
                    r.valid_res = 1'b1;
                    r.saturated = longint'(ch_acc[k]) > longint'(sat_level_reg) * cnt;
                end
                pending_stats.push_back(r);
            end
        end
        clear_run_state();
    endfunction

    always @(posedge clk)
    begin
        stat_rec_t got;
        stat_rec_t want;
        if (rst_n)
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                track_sample(samples_ch.sample, samples_ch.end_of_run);
                samples_taken++;
            end
            if (results_ch.valid && results_ch.ready)
            begin
                got.kind         = isps_pkg::kind_t'(results_ch.kind);
                got.index        = results_ch.index;
                got.average      = results_ch.average;
                got.swing        = results_ch.swing;
                got.valid_res    = results_ch.valid_res;
                got.saturated    = results_ch.saturated;
                got.final_result = results_ch.final_result;
                if (pending_stats.size() == 0)
                begin
                    if (faults < 10)
                        $display("unexpected result: kind %0d index %0d average %0d",
                                 got.kind, got.index, got.average);
                    faults++;
                end
                else
                begin
                    want = pending_stats.pop_front();
                    results_checked++;
                    if (got.kind !== want.kind || got.index !== want.index
                        || got.average !== want.average || got.swing !== want.swing
                        || got.valid_res !== want.valid_res
                        || got.saturated !== want.saturated
                        || got.final_result !== want.final_result)
                    begin
                        if (faults < 10)
                        begin
                            $display("mismatch at result %0d", results_checked);
                            $display({"  expected kind %0d index %0d average %0d",
                                      " swing %0d valid %0b sat %0b final %0b"},
                                     want.kind, want.index, want.average, want.swing,
                                     want.valid_res, want.saturated, want.final_result);
                            $display({"  actual   kind %0d index %0d average %0d",
                                      " swing %0d valid %0b sat %0b final %0b"},
                                     got.kind, got.index, got.average, got.swing,
                                     got.valid_res, got.saturated, got.final_result);
                        end
                        faults++;
                    end
                end
            end
        end
    end

    // result receiver: random stalls, one long hold-off on request
    initial
    begin
        results_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_results)
            begin
                results_ch.ready = 1'b0;
                holding = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holding      = 1'b0;
                hold_results = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                results_ch.ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            else
            begin
                results_ch.ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    // enter and leave at a falling edge; valid stays high for a following transfer
    task automatic send_sample(logic [isps_pkg::SAMPLE_W-1:0] x, logic eor);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            samples_ch.valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        samples_ch.sample     = x;
        samples_ch.end_of_run = eor;
        samples_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_register(isps_pkg::cfg_reg_t target,
                                  logic [isps_pkg::CFG_W-1:0] value);
        samples_ch.valid = 1'b0;
        while (pending_stats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = target;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        if (target == isps_pkg::REG_PEDESTAL)
            pedestal_reg = value;
        else
            sat_level_reg = value;
    endtask

    function automatic logic [isps_pkg::SAMPLE_W-1:0] pick_sample(
        logic [isps_pkg::SAMPLE_W-1:0] centre);
        logic [isps_pkg::SAMPLE_W-1:0] x;
        case ($urandom_range(0, 7))
            0:       x = '0;
            1:       x = '1;
            2, 3:    x = isps_pkg::SAMPLE_W'(centre + $urandom_range(0, 6) - 3);
            default: x = isps_pkg::SAMPLE_W'($urandom);
        endcase
        return x;
    endfunction

    task automatic random_run(int len);
        logic [isps_pkg::SAMPLE_W-1:0] centre;
        int i;
        case ($urandom_range(0, 3))
            0:       centre = sat_level_reg;
            1:       centre = pedestal_reg;
            default: centre = isps_pkg::SAMPLE_W'($urandom);
        endcase
        for (i = 0; i < len; i++)
            send_sample(pick_sample(centre), i == len - 1);
    endtask

    function automatic dir_row_t sample_row(logic [isps_pkg::SAMPLE_W-1:0] x, logic eor,
                                            int typed_at);
        dir_row_t r;
        r.op       = ROW_SAMPLE;
        r.target   = isps_pkg::REG_PEDESTAL;
        r.value    = x;
        r.eor      = eor;
        r.typed_at = typed_at;
        return r;
    endfunction

    function automatic dir_row_t config_row(isps_pkg::cfg_reg_t target,
                                            logic [isps_pkg::CFG_W-1:0] value);
        dir_row_t r;
        r.op       = ROW_CONFIG;
        r.target   = target;
        r.value    = value;
        r.eor      = 1'b0;
        r.typed_at = -1;
        return r;
    endfunction

    initial
    begin
        dir_row_t directed_rows [$];
        int r;
        int k;
        int ph;
        int start;
        int drain;

        samples_ch.valid      = 1'b0;
        samples_ch.sample     = '0;
        samples_ch.end_of_run = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = isps_pkg::REG_PEDESTAL;
        cfg_data              = '0;
        rst_n                 = 1'b0;
        clear_run_state();

        for (r = 0; r < 4; r++)
            for (k = 0; k < 4; k++)
                typed_table[r*6 + k] = stat_rec(isps_pkg::KIND_LAG, k, 0, 0, 0, 0, 0);
        typed_table[4]  = stat_rec(isps_pkg::KIND_CHANNEL, 0, 13631487, 0, 1, 1, 0);
        typed_table[5]  = stat_rec(isps_pkg::KIND_CHANNEL, 1, 0, 0, 0, 0, 1);
        typed_table[6]  = stat_rec(isps_pkg::KIND_LAG, 0, 16777215, 0, 1, 0, 0);
        typed_table[10] = stat_rec(isps_pkg::KIND_CHANNEL, 0, -3145728, 0, 1, 0, 0);
        typed_table[11] = stat_rec(isps_pkg::KIND_CHANNEL, 1, 13631487, 0, 1, 1, 1);
        typed_table[16] = stat_rec(isps_pkg::KIND_CHANNEL, 0, 0, 0, 1, 0, 0);
        typed_table[17] = stat_rec(isps_pkg::KIND_CHANNEL, 1, 0, 0, 0, 0, 1);
        typed_table[22] = stat_rec(isps_pkg::KIND_CHANNEL, 0, -16777215, 0, 1, 0, 0);
        typed_table[23] = stat_rec(isps_pkg::KIND_CHANNEL, 1, 0, 0, 0, 0, 1);

        directed_rows.push_back(sample_row(24'hFFFFFF, 1'b1, 0));
        directed_rows.push_back(sample_row(24'h000000, 1'b0, -1));
        directed_rows.push_back(sample_row(24'hFFFFFF, 1'b1, 6));
        directed_rows.push_back(sample_row(24'h00000A, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h0003E8, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h000005, 1'b0, -1));
        directed_rows.push_back(sample_row(24'hFFFFFF, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h000000, 1'b1, -1));
        directed_rows.push_back(sample_row(24'h123456, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h654321, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h800000, 1'b1, -1));
        directed_rows.push_back(sample_row(24'hAAAAAA, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h555555, 1'b0, -1));
        directed_rows.push_back(sample_row(24'hAAAAAA, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h555555, 1'b1, -1));
        directed_rows.push_back(config_row(isps_pkg::REG_PEDESTAL, 24'h000000));
        directed_rows.push_back(config_row(isps_pkg::REG_SAT_LEVEL, 24'h000000));
        directed_rows.push_back(sample_row(24'h000000, 1'b1, 12));
        directed_rows.push_back(config_row(isps_pkg::REG_PEDESTAL, 24'hFFFFFF));
        directed_rows.push_back(config_row(isps_pkg::REG_SAT_LEVEL, 24'hFFFFFF));
        directed_rows.push_back(sample_row(24'h000000, 1'b1, 18));
        directed_rows.push_back(config_row(isps_pkg::REG_PEDESTAL, 24'h300000));
        directed_rows.push_back(config_row(isps_pkg::REG_SAT_LEVEL, 24'h300000));
        directed_rows.push_back(sample_row(24'h300000, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h300000, 1'b1, -1));
        directed_rows.push_back(sample_row(24'h300001, 1'b0, -1));
        directed_rows.push_back(sample_row(24'h300000, 1'b1, -1));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CONFIG)
                write_register(directed_rows[i].target, directed_rows[i].value);
            else
            begin
                if (directed_rows[i].typed_at >= 0)
                    typed_pick = directed_rows[i].typed_at;
                send_sample(directed_rows[i].value, directed_rows[i].eor);
            end
        end

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:
                begin
                    write_register(isps_pkg::REG_PEDESTAL, 24'h000000);
                    write_register(isps_pkg::REG_SAT_LEVEL, 24'hFFFFFF);
                end
                2:
                begin
                    write_register(isps_pkg::REG_PEDESTAL, 24'hFFFFFF);
                    write_register(isps_pkg::REG_SAT_LEVEL, 24'h000000);
                end
                default:
                begin
                    write_register(isps_pkg::REG_PEDESTAL, isps_pkg::CFG_W'($urandom));
                    write_register(isps_pkg::REG_SAT_LEVEL, isps_pkg::CFG_W'($urandom));
                end
            endcase
            calm  = (ph == 3);
            start = items_sent;
            if (ph == 1)
            begin
                // stall the receiver and offer five short runs so that input backs up
                samples_ch.valid = 1'b0;
                hold_results     = 1'b1;
                wait (holding);
                @(negedge clk);
                for (r = 0; r < 5; r++)
                    random_run($urandom_range(2, 4));
            end
            while (items_sent - start < PHASE_ITEMS)
                random_run(($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                       : $urandom_range(9, 40));
        end

        samples_ch.valid = 1'b0;
        drain = 0;
        while (pending_stats.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (250) @(posedge clk);
        if (pending_stats.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_stats.size());
            faults += pending_stats.size();
        end

        $display("covered %0d samples in %0d runs, %0d results checked, %0d faults",
                 samples_taken, runs_seen, results_checked, faults);
        $display("register extremes, empty lags and channels, and a long result hold-off included");
        if (faults == 0)
            $display("tb_interleaved_sample_period_stats passed");
        else
            $display("tb_interleaved_sample_period_stats failed");
        $finish;
    end

endmodule

// File: interleaved_sample_period_stats.f
src/isps_pkg.sv
src/isps_if.sv
src/isps_front.sv
src/isps_queue.sv
src/isps_back.sv
src/interleaved_sample_period_stats.sv
verif/tb_interleaved_sample_period_stats.sv
